[hw/rtl/lbp_uniform_rotation_invariant_macros.svh]
// Assertion macros shared by the local binary pattern RTL.
`ifndef LBP_UNIFORM_ROTATION_INVARIANT_MACROS_SVH
`define LBP_UNIFORM_ROTATION_INVARIANT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define LBPRIU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbpriu: same-cycle check failed");
// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define LBPRIU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbpriu: next-cycle check failed");
`else
`define LBPRIU_ASSERT_IMP(label, ante, cons)
`define LBPRIU_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hw/rtl/lbpriu_pkg.sv]
// Types, constants and helper functions for the local binary pattern block.
package lbpriu_pkg;

    localparam int IMAGE_SIDE = 512;
    localparam int HIST_BINS  = 58;

    localparam int ADDR_W = $clog2(IMAGE_SIDE);
    localparam int PIX_W  = 8;
    localparam int CODE_W = 8;
    localparam int BIN_W  = 6;
    localparam int POS_W  = 9;
    localparam int ONES_W = 4;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [POS_W-1:0]  pos_t;

    // Window laid out row-major from the top-left pixel.
    typedef logic [8:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BIN_W-1:0]  bin;
        logic              uniform;
    } lbp_result_t;

    // Number of set bits in a pattern code.
    function automatic logic [ONES_W-1:0] ones8(input logic [CODE_W-1:0] v);
        logic [ONES_W-1:0] n;
        n = '0;
        for (int i = 0; i < CODE_W; i++)
        begin
            n = n + ONES_W'(v[i]);
        end
        return n;
    endfunction

    // Image coordinate resized to the width carried on the output.
    function automatic pos_t to_pos(input addr_t v);
        return POS_W'(v);
    endfunction

endpackage

[hw/rtl/lbp_uniform_rotation_invariant.sv]
// Top level of the streaming 3x3 rotation-invariant uniform local binary pattern block.
// Pixels of a square image arrive in raster order on the slave stream, one per beat:
// s_tdata holds the grey level and s_tuser marks the first pixel of a frame, which
// restarts the row and column counts. After the last pixel the counts wrap by themselves.
// For every interior centre pixel one beat leaves on the master stream with the pattern
// code, its bin, the uniform flag and the centre position; m_tlast marks the last
// interior pixel of the frame. Border pixels give no beat.
// The two previous rows live in two line memories with a registered read.
// A pixel reads its column on acceptance and writes the column back one stage later,
// so the block takes one pixel per clock while the output is not stalled. The result for
// a window passes through the first stage, the second stage and then the output register.
// Each column is revisited only a full row of beats later, so a read never needs the
// data of a write still in flight; only a restart mid-frame may read an entry while it
// is written, and such stale data is overwritten before any result depends on it.
// Reset clears the counts, the window and all valid flags; the line memories are not
// cleared and need no clearing pass. When the receiver stalls, the output register holds
// its beat, the stages behind it fill, and s_tready falls only once every stage is full.
`include "lbp_uniform_rotation_invariant_macros.svh"
module lbp_uniform_rotation_invariant
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] lbp_code, [13:8] lbp_bin, [22:14] centre_row,
                                   // [31:23] centre_col
    output logic        m_tuser,   // [0] is_uniform
    output logic        m_tlast    // frame_last
);

    localparam lbpriu_pkg::addr_t LAST_POS = lbpriu_pkg::ADDR_W'(lbpriu_pkg::IMAGE_SIDE - 1);
    localparam lbpriu_pkg::addr_t POS_ONE  = lbpriu_pkg::ADDR_W'(1);
    localparam lbpriu_pkg::addr_t POS_TWO  = lbpriu_pkg::ADDR_W'(2);

    // Line memories: the row two above and the row just above the incoming pixel.
    lbpriu_pkg::pix_t line_upper_mem  [lbpriu_pkg::IMAGE_SIDE];
    lbpriu_pkg::pix_t line_middle_mem [lbpriu_pkg::IMAGE_SIDE];

    logic               in_accept;
    lbpriu_pkg::addr_t  row_count_reg, row_count_next;
    lbpriu_pkg::addr_t  col_count_reg, col_count_next;
    lbpriu_pkg::addr_t  cur_row, cur_col;

    // First stage: accepted pixel with its position and the registered memory reads.
    logic               s1_valid_reg;
    lbpriu_pkg::pix_t   s1_pixel_reg;
    lbpriu_pkg::addr_t  s1_row_reg;
    lbpriu_pkg::addr_t  s1_col_reg;
    lbpriu_pkg::pix_t   up_rd_reg;
    lbpriu_pkg::pix_t   mid_rd_reg;
    logic               s1_adv;
    logic               s1_emit;

    // Second stage: window complete, position of the centre it describes.
    lbpriu_pkg::window_t window_reg;
    logic               s2_valid_reg;
    lbpriu_pkg::pos_t   s2_row_reg;
    lbpriu_pkg::pos_t   s2_col_reg;
    logic               s2_last_reg;
    logic               s2_adv;

    lbpriu_pkg::lbp_result_t pattern;

    // Output register.
    logic                    out_valid_reg;
    lbpriu_pkg::lbp_result_t out_res_reg;
    lbpriu_pkg::pos_t        out_row_reg;
    lbpriu_pkg::pos_t        out_col_reg;
    logic                    out_last_reg;

    // Each stage moves on when it holds an item and the one ahead is empty or moving.
    assign s2_adv    = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign in_accept = s_tvalid && s_tready;

    // A frame marker restarts the position before this pixel is placed.
    assign cur_row = s_tuser ? '0 : row_count_reg;
    assign cur_col = s_tuser ? '0 : col_count_reg;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (in_accept)
        begin
            if (cur_col == LAST_POS)
            begin
                col_count_next = '0;
                row_count_next = (cur_row == LAST_POS) ? '0 : cur_row + POS_ONE;
            end
            else
            begin
                col_count_next = cur_col + POS_ONE;
                row_count_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // Read on acceptance, write back the shifted column when the first stage moves on.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            line_upper_mem[s1_col_reg]  <= mid_rd_reg;
            line_middle_mem[s1_col_reg] <= s1_pixel_reg;
        end
        if (in_accept)
        begin
            up_rd_reg  <= line_upper_mem[cur_col];
            mid_rd_reg <= line_middle_mem[cur_col];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= s_tdata;
            s1_row_reg   <= cur_row;
            s1_col_reg   <= cur_col;
        end
    end

    assign s1_emit = (s1_row_reg >= POS_TWO) && (s1_col_reg >= POS_TWO);

    // The window slides one column left and takes the new column at the right.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (s1_adv)
        begin
            window_reg[0] <= window_reg[1];
            window_reg[1] <= window_reg[2];
            window_reg[2] <= up_rd_reg;
            window_reg[3] <= window_reg[4];
            window_reg[4] <= window_reg[5];
            window_reg[5] <= mid_rd_reg;
            window_reg[6] <= window_reg[7];
            window_reg[7] <= window_reg[8];
            window_reg[8] <= s1_pixel_reg;
        end
    end

    // Only pixels that complete an interior window occupy the second stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_emit;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_row_reg  <= lbpriu_pkg::to_pos(s1_row_reg - POS_ONE);
            s2_col_reg  <= lbpriu_pkg::to_pos(s1_col_reg - POS_ONE);
            s2_last_reg <= (s1_row_reg == LAST_POS) && (s1_col_reg == LAST_POS);
        end
    end

    lbpriu_pattern u_pattern
    (
        .window (window_reg),
        .result (pattern)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_res_reg  <= pattern;
            out_row_reg  <= s2_row_reg;
            out_col_reg  <= s2_col_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_col_reg, out_row_reg, out_res_reg.bin, out_res_reg.code};
    assign m_tuser  = out_res_reg.uniform;
    assign m_tlast  = out_last_reg;

    // A frame marker always leaves the counts just past the first pixel of row zero.
    `LBPRIU_ASSERT_NXT(a_frame_restart, in_accept && s_tuser,
        row_count_reg == '0 && col_count_reg == POS_ONE)
    // Border pixels never reach the output, so no centre sits on row or column zero.
    `LBPRIU_ASSERT_IMP(a_interior_only, out_valid_reg,
        out_row_reg != '0 && out_col_reg != '0)
    // Non-uniform codes all share the last histogram bin.
    `LBPRIU_ASSERT_IMP(a_nonuniform_bin, out_valid_reg && !out_res_reg.uniform,
        out_res_reg.bin == lbpriu_pkg::BIN_W'(lbpriu_pkg::HIST_BINS - 1))
    // A uniform code has at most eight neighbours set.
    `LBPRIU_ASSERT_IMP(a_uniform_bin, out_valid_reg && out_res_reg.uniform,
        out_res_reg.bin <= lbpriu_pkg::BIN_W'(8))

endmodule

[hw/rtl/lbpriu_pattern.sv]
// Pattern code and rotation-invariant uniform bin of one 3x3 window.
module lbpriu_pattern
(
    input  lbpriu_pkg::window_t     window,
    output lbpriu_pkg::lbp_result_t result
);

    lbpriu_pkg::pix_t                      centre;
    logic [lbpriu_pkg::CODE_W-1:0]         code;
    logic [lbpriu_pkg::CODE_W-1:0]         rotated;
    logic [lbpriu_pkg::ONES_W-1:0]         transitions;
    logic                                  uniform;

    assign centre = window[4];

    // Bit 7 is top-left, running clockwise round the centre to bit 0 at left.
    assign code = {window[0] > centre, window[1] > centre, window[2] > centre,
                   window[5] > centre, window[8] > centre, window[7] > centre,
                   window[6] > centre, window[3] > centre};

    assign rotated     = {code[0], code[lbpriu_pkg::CODE_W-1:1]};
    assign transitions = lbpriu_pkg::ones8(code ^ rotated);
    assign uniform     = (transitions <= lbpriu_pkg::ONES_W'(2));

    always_comb
    begin
        result.code    = code;
        result.uniform = uniform;
        if (uniform)
        begin
            result.bin = lbpriu_pkg::BIN_W'(lbpriu_pkg::ones8(code));
        end
        else
        begin
            result.bin = lbpriu_pkg::BIN_W'(lbpriu_pkg::HIST_BINS - 1);
        end
    end

endmodule
